@@ rtl/vfc_pkg.sv @@
package vfc_pkg;

  // Datapath widths of the shared rotation unit.
  localparam int CW = 52;
  localparam int ZW = 34;
  // Magnitude widths of the quotient unit.
  localparam int DVD_W = 42;
  localparam int DVS_W = 48;

  // Inverse of the rotation gain, scaled by 2^32.
  localparam logic [31:0] GAIN_INV = 32'd2608131496;
  // A quarter turn, where 2^31 stands for pi.
  localparam logic signed [ZW-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [ZW-1:0] NQUARTER = -34'sd1073741824;
  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [1:0] {
    OP_INERTIAL = 2'd0,
    OP_BODY     = 2'd1,
    OP_FIX      = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef struct packed {
    logic start;
    logic vec;
  } cord_ctl_t;

  // Arctangent of 2^-i, with 2^31 standing for pi.
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/velocity_frame_converter.sv @@
// Velocity frame converter.
// An item enters on the in_ channel (valid/ready) and selects one of three
// operations: rotate an inertial velocity into the body frame, rotate a body
// velocity into the inertial frame, or turn a position fix into a velocity
// by dividing the change since the previous fix by the elapsed time.
// The block works on one item at a time; in_ready is high only while idle.
// Each item gives at most one result on the out_ channel (valid/ready).
// An inertial velocity passes the rotation unit only; a body velocity then also
// passes vectoring and the bit-serial square root side by side; a fix that yields
// a velocity first passes the bit-serial dividers, then rotation and the rest.
// The rotation unit does one micro-rotation per cycle, the square root one root
// bit per cycle and the dividers one quotient bit per cycle. in_ready rises
// together with out_valid, once the result is in the output register.
// Items that give no result leave the block idle.
// The result sits in an output register, so the block takes the next item
// while the receiver stalls; it only waits there if a second result is ready
// before the first has been taken.
// Reset clears the control state and the stored previous fix.
module velocity_frame_converter #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic               in_sample_valid,
  input  logic signed [31:0] in_comp_a,
  input  logic signed [31:0] in_comp_b,
  input  logic signed [15:0] in_heading,
  input  logic [47:0]        in_time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_body_u,
  output logic signed [31:0] out_body_v,
  output logic signed [31:0] out_inertial_x,
  output logic signed [31:0] out_inertial_y,
  output logic [30:0]        out_ground_speed,
  output logic signed [15:0] out_course_angle,
  output logic               out_polar_valid
);
  import vfc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_ROT   = 5'b00100,
    S_POLAR = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  op_t                  op_r;
  op_t                  in_op_c;
  logic signed [15:0]   psi_r;
  logic signed [31:0]   ix_r, iy_r, bu_r, bv_r;
  logic signed [32:0]   dx_r, dy_r;
  logic [47:0]          dt_r;
  logic signed [31:0]   last_x_r, last_y_r;
  logic [47:0]          last_t_r;
  logic [30:0]          speed_r;
  logic [15:0]          course_r;
  logic                 vec_done_r, sq_done_r;
  cord_ctl_t            cord_ctl_r;
  logic                 div_start_r, sq_start_r;
  logic                 out_valid_r;
  logic signed [31:0]   out_bu_r, out_bv_r, out_ix_r, out_iy_r;
  logic [30:0]          out_speed_r;
  logic [15:0]          out_course_r;
  logic                 out_polar_r;

  logic                 have_fix;
  logic                 out_free;
  logic signed [ZW-1:0] psi_ext, cord_z_in;
  logic signed [31:0]   cord_a_in, cord_b_in;
  logic                 cord_done;
  logic signed [CW-1:0] cord_x, cord_y;
  logic signed [ZW-1:0] cord_z;
  logic signed [31:0]   rx, ry;
  logic [ZW-1:0]        course_sum;
  logic                 div_done, div_y_done;
  logic signed [31:0]   qx, qy;
  logic                 sq_done;
  logic [30:0]          sq_speed;

  // Drop the guard bits with rounding half up, then clamp to 32 bits.
  function automatic logic signed [31:0] round_sat(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic [CW-17:0]       s;
    t = v + CW'(32768);
    s = t[CW-1:16];
    if ((&s[CW-17:31]) || !(|s[CW-17:31])) begin
      return $signed(s[31:0]);
    end
    return s[CW-17] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  assign in_op_c  = op_t'(in_op);
  assign in_ready = (state_r == S_IDLE);
  assign have_fix = (last_t_r != 48'd0) && (last_t_r < in_time_ms);
  assign out_free = !out_valid_r || out_ready;

  // Rotation operands: body velocity for the body item, otherwise the
  // inertial registers, which hold the input, the quotients or the body rotation result.
  assign psi_ext   = $signed({{2{psi_r[15]}}, psi_r, 16'h0000});
  assign cord_z_in = (op_r == OP_BODY) ? psi_ext : -psi_ext;
  assign cord_a_in = ((state_r == S_ROT) && (op_r == OP_BODY)) ? bu_r : ix_r;
  assign cord_b_in = ((state_r == S_ROT) && (op_r == OP_BODY)) ? bv_r : iy_r;

  vfc_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (cord_ctl_r),
    .a_i    (cord_a_in),
    .b_i    (cord_b_in),
    .z_i    (cord_z_in),
    .done_o (cord_done),
    .x_o    (cord_x),
    .y_o    (cord_y),
    .z_o    (cord_z)
  );

  vfc_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start_r),
    .diff_i  (dx_r),
    .dvs_i   (dt_r),
    .done_o  (div_done),
    .q_o     (qx)
  );

  vfc_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start_r),
    .diff_i  (dy_r),
    .dvs_i   (dt_r),
    .done_o  (div_y_done),
    .q_o     (qy)
  );

  vfc_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sq_start_r),
    .x_i     (ix_r),
    .y_i     (iy_r),
    .done_o  (sq_done),
    .speed_o (sq_speed)
  );

  assign rx         = round_sat(cord_x);
  assign ry         = round_sat(cord_y);
  assign course_sum = ZW'(cord_z + ZW'(32768));

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op_c)
            OP_INERTIAL: state_nxt = S_ROT;
            OP_BODY:     state_nxt = in_sample_valid ? S_ROT : S_IDLE;
            OP_FIX:      state_nxt = (in_sample_valid && have_fix) ? S_DIV : S_IDLE;
            OP_UNUSED:   state_nxt = S_IDLE;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (div_done && div_y_done) begin
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (cord_done) begin
          state_nxt = (op_r == OP_INERTIAL) ? S_OUT : S_POLAR;
        end
      end
      S_POLAR: begin
        if ((vec_done_r || cord_done) && (sq_done_r || sq_done)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers and unit start pulses.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_t_r    <= '0;
      cord_ctl_r  <= '0;
      div_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
      vec_done_r  <= 1'b0;
      sq_done_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cord_ctl_r  <= '0;
      div_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= in_op_c;
            psi_r <= in_heading;
            ix_r  <= in_comp_a;
            iy_r  <= in_comp_b;
            bu_r  <= in_comp_a;
            bv_r  <= in_comp_b;
            dx_r  <= 33'(in_comp_a) - 33'(last_x_r);
            dy_r  <= 33'(in_comp_b) - 33'(last_y_r);
            dt_r  <= in_time_ms - last_t_r;
            if ((in_op_c == OP_FIX) && in_sample_valid) begin
              last_x_r    <= in_comp_a;
              last_y_r    <= in_comp_b;
              last_t_r    <= in_time_ms;
              div_start_r <= have_fix;
            end
            if ((in_op_c == OP_INERTIAL) || ((in_op_c == OP_BODY) && in_sample_valid)) begin
              cord_ctl_r <= '{start: 1'b1, vec: 1'b0};
            end
          end
        end
        S_DIV: begin
          if (div_done && div_y_done) begin
            ix_r       <= qx;
            iy_r       <= qy;
            cord_ctl_r <= '{start: 1'b1, vec: 1'b0};
          end
        end
        S_ROT: begin
          if (cord_done) begin
            if (op_r == OP_BODY) begin
              ix_r <= rx;
              iy_r <= ry;
            end else begin
              bu_r <= rx;
              bv_r <= ry;
            end
            if (op_r != OP_INERTIAL) begin
              cord_ctl_r <= '{start: 1'b1, vec: 1'b1};
              sq_start_r <= 1'b1;
              vec_done_r <= 1'b0;
              sq_done_r  <= 1'b0;
            end
          end
        end
        S_POLAR: begin
          if (cord_done) begin
            vec_done_r <= 1'b1;
            course_r   <= ((ix_r == 32'sd0) && (iy_r == 32'sd0)) ? 16'h0000
                                                                  : course_sum[31:16];
          end
          if (sq_done) begin
            sq_done_r <= 1'b1;
            speed_r   <= sq_speed;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_bu_r     <= bu_r;
            out_bv_r     <= bv_r;
            out_ix_r     <= ix_r;
            out_iy_r     <= iy_r;
            out_polar_r  <= (op_r != OP_INERTIAL);
            out_speed_r  <= (op_r != OP_INERTIAL) ? speed_r : 31'd0;
            out_course_r <= (op_r != OP_INERTIAL) ? course_r : 16'h0000;
          end
        end
        default: begin
          vec_done_r <= 1'b0;
          sq_done_r  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_body_u       = out_bu_r;
  assign out_body_v       = out_bv_r;
  assign out_inertial_x   = out_ix_r;
  assign out_inertial_y   = out_iy_r;
  assign out_ground_speed = out_speed_r;
  assign out_course_angle = $signed(out_course_r);
  assign out_polar_valid  = out_polar_r;

endmodule

@@ rtl/vfc_div.sv @@
module vfc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic signed [32:0]           diff_i,
  input  logic [vfc_pkg::DVS_W-1:0]    dvs_i,
  output logic                         done_o,
  output logic signed [31:0]           q_o
);
  import vfc_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [5:0]       cnt_r;
  logic             neg_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r;
  logic [32:0]      mag;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  // Magnitude of the position change; the scaling by 1000 happens on load.
  assign mag = diff_i[32] ? 33'(-diff_i) : 33'(diff_i);

  // One quotient bit per cycle, restoring.
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start_i) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          neg_r  <= diff_i[32];
          rem_r  <= '0;
          dvd_r  <= DVD_W'(mag) * DVD_W'(MS_PER_S);
        end
      end else begin
        rem_r <= ge ? DVS_W'(rem_sh - {1'b0, dvs_i}) : DVS_W'(rem_sh);
        dvd_r <= {dvd_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    if (!neg_r) begin
      q_o = (|dvd_r[DVD_W-1:31]) ? 32'sh7FFFFFFF : $signed(dvd_r[31:0]);
    end else if ((|dvd_r[DVD_W-1:32]) || (dvd_r[31] && (|dvd_r[30:0]))) begin
      q_o = 32'sh80000000;
    end else begin
      q_o = $signed(32'(-dvd_r[31:0]));
    end
  end

  assign done_o = done_r;

endmodule

@@ rtl/vfc_sqrt.sv @@
module vfc_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  output logic               done_o,
  output logic [30:0]        speed_o
);
  import vfc_pkg::*;

  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001,
    SQ_X    = 4'b0010,
    SQ_Y    = 4'b0100,
    SQ_ITER = 4'b1000
  } sq_state_t;

  sq_state_t          state_r;
  logic               done_r;
  logic [4:0]         cnt_r;
  logic [63:0]        rad_r;
  logic [34:0]        rem_r;
  logic [31:0]        root_r;
  logic signed [31:0] mul_src;
  logic signed [63:0] sq;
  logic [34:0]        rem_sh;
  logic [34:0]        trial;
  logic               ge;

  // One squarer, used for x and then y.
  assign mul_src = (state_r == SQ_X) ? x_i : y_i;
  assign sq      = mul_src * mul_src;

  // Two radicand bits per cycle give one root bit.
  assign rem_sh = {rem_r[32:0], rad_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        SQ_IDLE: begin
          if (start_i) begin
            state_r <= SQ_X;
          end
        end
        SQ_X: begin
          rad_r   <= 64'(sq);
          state_r <= SQ_Y;
        end
        SQ_Y: begin
          rad_r   <= rad_r + 64'(sq);
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= SQ_ITER;
        end
        SQ_ITER: begin
          rem_r  <= ge ? 35'(rem_sh - trial) : rem_sh;
          root_r <= {root_r[30:0], ge};
          rad_r  <= {rad_r[61:0], 2'b00};
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= SQ_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= SQ_IDLE;
      endcase
    end
  end

  assign done_o  = done_r;
  assign speed_o = root_r[31] ? 31'h7FFFFFFF : root_r[30:0];

endmodule

@@ rtl/vfc_cordic.sv @@
module vfc_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vfc_pkg::cord_ctl_t             ctl_i,
  input  logic signed [31:0]             a_i,
  input  logic signed [31:0]             b_i,
  input  logic signed [vfc_pkg::ZW-1:0]  z_i,
  output logic                           done_o,
  output logic signed [vfc_pkg::CW-1:0]  x_o,
  output logic signed [vfc_pkg::CW-1:0]  y_o,
  output logic signed [vfc_pkg::ZW-1:0]  z_o
);
  import vfc_pkg::*;

  localparam int CNT_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_MULX = 5'b00010,
    PH_MULY = 5'b00100,
    PH_QUAD = 5'b01000,
    PH_ITER = 5'b10000
  } ph_t;

  ph_t                  phase_r;
  logic                 done_r;
  logic                 vec_r;
  logic [CNT_W-1:0]     cnt_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;

  logic signed [31:0]   mul_src;
  logic signed [64:0]   prod;
  logic signed [CW-1:0] prod_ext;
  logic signed [CW-1:0] a_ext, b_ext;
  logic signed [CW-1:0] qx, qy, qt;
  logic signed [ZW-1:0] qz;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] atn;
  logic                 sigma;

  // Prescale by the inverse gain, one component per cycle.
  assign mul_src  = (phase_r == PH_MULX) ? a_i : b_i;
  assign prod     = 65'(mul_src) * $signed({1'b0, GAIN_INV});
  assign prod_ext = CW'($signed(prod[63:16]));

  // Inputs with the guard bits appended, for vectoring.
  assign a_ext = {{(CW-48){a_i[31]}}, a_i, 16'h0000};
  assign b_ext = {{(CW-48){b_i[31]}}, b_i, 16'h0000};

  // Up to two quarter turns bring the angle into range.
  always_comb begin
    qx = x_r;
    qy = y_r;
    qz = z_r;
    qt = x_r;
    for (int k = 0; k < 2; k++) begin
      if (qz > QUARTER) begin
        qt = qx;
        qx = -qy;
        qy = qt;
        qz = qz - QUARTER;
      end else if (qz < NQUARTER) begin
        qt = qx;
        qx = qy;
        qy = -qt;
        qz = qz + QUARTER;
      end
    end
  end

  // One micro-rotation per cycle.
  assign dx    = y_r >>> cnt_r;
  assign dy    = x_r >>> cnt_r;
  assign atn   = $signed(ZW'(atan_lut(5'(cnt_r))));
  assign sigma = vec_r ? !(y_r > 0) : !z_r[ZW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        PH_IDLE: begin
          if (ctl_i.start) begin
            vec_r <= ctl_i.vec;
            cnt_r <= '0;
            if (ctl_i.vec) begin
              // Vectors in the left half plane are turned by a quarter first.
              if (!a_i[31]) begin
                x_r <= a_ext;
                y_r <= b_ext;
                z_r <= '0;
              end else if (!b_i[31]) begin
                x_r <= b_ext;
                y_r <= -a_ext;
                z_r <= QUARTER;
              end else begin
                x_r <= -b_ext;
                y_r <= a_ext;
                z_r <= NQUARTER;
              end
              phase_r <= PH_ITER;
            end else begin
              z_r     <= z_i;
              phase_r <= PH_MULX;
            end
          end
        end
        PH_MULX: begin
          x_r     <= prod_ext;
          phase_r <= PH_MULY;
        end
        PH_MULY: begin
          y_r     <= prod_ext;
          phase_r <= PH_QUAD;
        end
        PH_QUAD: begin
          x_r     <= qx;
          y_r     <= qy;
          z_r     <= qz;
          phase_r <= PH_ITER;
        end
        PH_ITER: begin
          if (sigma) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - atn;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + atn;
          end
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(CORDIC_STAGES - 1)) begin
            phase_r <= PH_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  assign done_o = done_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule

@@ tb/velocity_frame_converter_tb.sv @@
module velocity_frame_converter_tb;
  import vfc_pkg::*;

  localparam int STAGES = 16;
  localparam int GUARD_BITS = 16;
  localparam longint QTURN = 64'sd1073741824;
  localparam longint GAIN = 64'sd2608131496;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    op_t         op;
    logic        sample_valid;
    logic [31:0] comp_a;
    logic [31:0] comp_b;
    logic [15:0] heading;
    logic [47:0] time_ms;
  } frame_item_t;

  typedef struct {
    logic [31:0] body_u;
    logic [31:0] body_v;
    logic [31:0] inertial_x;
    logic [31:0] inertial_y;
    logic [30:0] ground_speed;
    logic [15:0] course_angle;
    logic        polar_valid;
  } velocity_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic in_sample_valid = 1'b0;
  logic signed [31:0] in_comp_a = '0;
  logic signed [31:0] in_comp_b = '0;
  logic signed [15:0] in_heading = '0;
  logic [47:0] in_time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_body_u, out_body_v, out_inertial_x, out_inertial_y;
  logic [30:0] out_ground_speed;
  logic signed [15:0] out_course_angle;
  logic out_polar_valid;

  frame_item_t pending_items[$];
  velocity_t   expected_velocities[$];

  // Stored previous fix, mirrored from the block.
  logic [31:0] prev_fix_x, prev_fix_y;
  logic [47:0] prev_fix_time;

  longint arctan_steps[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  int items_sent, items_accepted, results_seen, mismatches, polar_results;
  int idle_cycles;
  bit burst_in, burst_out;
  int in_wait, out_wait;

  velocity_frame_converter #(.CORDIC_STAGES(STAGES)) i_dut (.*);

  always #2 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rotate (a, b) anticlockwise by z, where 2^31 stands for pi.
  task automatic rotate_vec(input longint a, input longint b, input longint z,
                            output longint ra, output longint rb);
    longint x, y, t, dx, dy;
    x = (a * GAIN) >>> (32 - GUARD_BITS);
    y = (b * GAIN) >>> (32 - GUARD_BITS);
    for (int i = 0; i < 2; i++) begin
      if (z > QTURN) begin
        t = x; x = -y; y = t; z -= QTURN;
      end else if (z < -QTURN) begin
        t = x; x = y; y = -t; z += QTURN;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_steps[i];
      end else begin
        x += dx; y -= dy; z += arctan_steps[i];
      end
    end
    ra = clamp32((x + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS);
    rb = clamp32((y + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS);
  endtask

  function automatic logic [15:0] course_of(longint xa, longint ya);
    longint x, y, z, t, dx, dy;
    if (xa == 0 && ya == 0) return '0;
    x = xa <<< GUARD_BITS;
    y = ya <<< GUARD_BITS;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QTURN;
      end else begin
        t = x; x = -y; y = t; z = -QTURN;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_steps[i];
      end else begin
        x -= dx; y += dy; z -= arctan_steps[i];
      end
    end
    return 16'((z + 64'sd32768) >>> 16);
  endfunction

  // Integer square root of x^2 + y^2, saturated to 31 bits.
  function automatic logic [30:0] speed_of(longint x, longint y);
    bit [63:0] n, r, b;
    n = 64'(x * x) + 64'(y * y);
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return (r > 64'h7FFFFFFF) ? 31'h7FFFFFFF : r[30:0];
  endfunction

  // Work out the result of one accepted item and update the stored fix.
  task automatic predict_velocity(input frame_item_t it);
    longint a, b, z, bu, bv, ix, iy, dt;
    bit have_prev;
    velocity_t v;
    a = longint'($signed(it.comp_a));
    b = longint'($signed(it.comp_b));
    z = longint'($signed(it.heading)) * 65536;
    case (it.op)
      OP_INERTIAL: begin
        rotate_vec(a, b, -z, bu, bv);
        ix = a; iy = b;
      end
      OP_BODY: begin
        if (!it.sample_valid) return;
        rotate_vec(a, b, z, ix, iy);
        bu = a; bv = b;
      end
      OP_FIX: begin
        if (!it.sample_valid) return;
        have_prev = prev_fix_time != 0 && prev_fix_time < it.time_ms;
        if (have_prev) begin
          dt = longint'({16'd0, it.time_ms - prev_fix_time});
          ix = clamp32((a - longint'($signed(prev_fix_x))) * 1000 / dt);
          iy = clamp32((b - longint'($signed(prev_fix_y))) * 1000 / dt);
          rotate_vec(ix, iy, -z, bu, bv);
        end
        prev_fix_x = it.comp_a;
        prev_fix_y = it.comp_b;
        prev_fix_time = it.time_ms;
        if (!have_prev) return;
      end
      default: return;
    endcase
    v.body_u = 32'(bu);
    v.body_v = 32'(bv);
    v.inertial_x = 32'(ix);
    v.inertial_y = 32'(iy);
    v.polar_valid = it.op != OP_INERTIAL;
    v.ground_speed = v.polar_valid ? speed_of(ix, iy) : '0;
    v.course_angle = v.polar_valid ? course_of(ix, iy) : '0;
    expected_velocities.push_back(v);
  endtask

  task automatic add_item(op_t op, logic sv, logic [31:0] a, logic [31:0] b,
                          logic [15:0] h, logic [47:0] t);
    frame_item_t it;
    it.op = op; it.sample_valid = sv; it.comp_a = a; it.comp_b = b;
    it.heading = h; it.time_ms = t;
    pending_items.push_back(it);
    items_sent++;
  endtask

  function automatic logic [31:0] rand_velocity();
    // Mostly realistic speeds, sometimes the whole range.
    if ($urandom_range(0, 3) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 2 * 2097152)) - 2097152);
  endfunction

  // Input driver: takes items from the pending queue with random gaps.
  always @(posedge clk) begin
    frame_item_t it;
    bit fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait = 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        predict_velocity('{op_t'(in_op), in_sample_valid, in_comp_a, in_comp_b,
                           in_heading, in_time_ms});
        items_accepted++;
        if ($urandom_range(0, 63) == 0) burst_in = ~burst_in;
        in_wait = burst_in ? 0 : $urandom_range(0, 15);
      end
      if (!in_valid || fire) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_op <= it.op;
          in_sample_valid <= it.sample_valid;
          in_comp_a <= it.comp_a;
          in_comp_b <= it.comp_b;
          in_heading <= it.heading;
          in_time_ms <= it.time_ms;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted item against the oldest expectation.
  always @(posedge clk) begin
    velocity_t e;
    bit fire, bad;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else begin
      fire = out_valid && out_ready;
      if (fire) begin
        results_seen++;
        if (expected_velocities.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
        end else begin
          e = expected_velocities.pop_front();
          bad = e.body_u != out_body_u || e.body_v != out_body_v ||
                e.inertial_x != out_inertial_x || e.inertial_y != out_inertial_y ||
                e.ground_speed != out_ground_speed ||
                e.course_angle != out_course_angle ||
                e.polar_valid != out_polar_valid;
          if (e.polar_valid) polar_results++;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: exp u=%h v=%h x=%h y=%h spd=%h crs=%h pv=%b",
                       results_seen, e.body_u, e.body_v, e.inertial_x,
                       e.inertial_y, e.ground_speed, e.course_angle, e.polar_valid);
              $display("result %0d: got u=%h v=%h x=%h y=%h spd=%h crs=%h pv=%b",
                       results_seen, out_body_u, out_body_v, out_inertial_x,
                       out_inertial_y, out_ground_speed, out_course_angle,
                       out_polar_valid);
            end
          end
        end
        if ($urandom_range(0, 63) == 0) burst_out = ~burst_out;
        out_wait = burst_out ? 0 : $urandom_range(0, 15);
      end
      if (!out_ready || fire) begin
        if (out_wait > 0) begin
          out_wait--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 expected_velocities.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [47:0] now_ms;
    logic [31:0] px, py;
    int sel;
    prev_fix_x = '0;
    prev_fix_y = '0;
    prev_fix_time = '0;
    idle_cycles = 0;

    // Directed part: extremes, every operation, fix timing cases.
    add_item(OP_INERTIAL, 1'b0, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 48'd0);
    add_item(OP_INERTIAL, 1'b1, 32'h80000000, 32'h7FFFFFFF, 16'h7FFF, '1);
    add_item(OP_INERTIAL, 1'b0, 32'h00010000, 32'h0, 16'h4000, 48'd0);
    add_item(OP_BODY, 1'b1, 32'h0, 32'h0, 16'h1234, 48'd0);
    add_item(OP_BODY, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h2000, 48'd0);
    add_item(OP_BODY, 1'b1, 32'h80000000, 32'h80000000, 16'hC000, 48'd0);
    add_item(OP_BODY, 1'b0, 32'h00050000, 32'h00030000, 16'h0100, 48'd0);
    add_item(OP_BODY, 1'b1, 32'hFFFF0000, 32'h0, 16'h0, 48'd0);
    add_item(OP_FIX, 1'b1, 32'h00100000, 32'h00200000, 16'h0, 48'd1000);
    add_item(OP_FIX, 1'b1, 32'h00180000, 32'h00100000, 16'h0800, 48'd2000);
    add_item(OP_FIX, 1'b1, 32'h00180000, 32'h00100000, 16'h0800, 48'd2000);
    add_item(OP_FIX, 1'b1, 32'h00200000, 32'h00100000, 16'h0, 48'd1500);
    add_item(OP_FIX, 1'b0, 32'h7FFFFFFF, 32'h0, 16'h0, 48'd9000);
    add_item(OP_FIX, 1'b1, 32'h00200000, 32'h00100000, 16'h0, 48'd2500);
    add_item(OP_FIX, 1'b1, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 48'd2501);
    add_item(OP_FIX, 1'b1, 32'h7FFFFFFF, 32'h80000000, 16'h7FFF, '1);
    add_item(OP_UNUSED, 1'b1, 32'h12345678, 32'h9ABCDEF0, 16'h1111, 48'd5);
    add_item(OP_FIX, 1'b1, 32'h0, 32'h0, 16'h0, 48'd0);
    add_item(OP_FIX, 1'b1, 32'h0, 32'h0, 16'h0, 48'd10);

    // Random part: fix sequences with advancing time, both rotations, plus noise.
    now_ms = 48'd10;
    px = '0;
    py = '0;
    for (int n = 0; n < 600; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        add_item(OP_INERTIAL, 1'($urandom()), rand_velocity(), rand_velocity(),
                 16'($urandom()), {16'($urandom()), 32'($urandom())});
      end else if (sel < 40) begin
        add_item(OP_BODY, $urandom_range(0, 9) != 0, rand_velocity(),
                 rand_velocity(), 16'($urandom()), {16'($urandom()), 32'($urandom())});
      end else if (sel < 85) begin
        if ($urandom_range(0, 19) == 0) now_ms = {16'($urandom()), 32'($urandom())};
        else now_ms += ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(20, 3000);
        if ($urandom_range(0, 9) == 0) begin
          px = $urandom();
          py = $urandom();
        end else begin
          px += 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
          py += 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        end
        add_item(OP_FIX, 1'b1, px, py, 16'($urandom()), now_ms);
      end else begin
        case ($urandom_range(0, 3))
          0: add_item(OP_UNUSED, 1'($urandom()), $urandom(), $urandom(),
                      16'($urandom()), {16'($urandom()), 32'($urandom())});
          1: add_item(OP_FIX, 1'b0, $urandom(), $urandom(), 16'($urandom()),
                      now_ms + 1);
          2: add_item(OP_FIX, 1'b1, px, py, 16'($urandom()),
                      now_ms - $urandom_range(0, 500));
          default: add_item(OP_FIX, 1'b1, px, py, 16'($urandom()), 48'd0);
        endcase
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_valid || expected_velocities.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items accepted of %0d, %0d results checked, %0d with speed and course",
             items_accepted, items_sent, results_seen, polar_results);
    if (mismatches == 0 && expected_velocities.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               expected_velocities.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/vfc_pkg.sv
rtl/vfc_div.sv
rtl/vfc_sqrt.sv
rtl/vfc_cordic.sv
rtl/velocity_frame_converter.sv
tb/velocity_frame_converter_tb.sv
